FILE: design/greedy_ligature_span_detector_assert.svh
// Assertion macros shared by the ligature span detector.
`ifndef GREEDY_LIGATURE_SPAN_DETECTOR_ASSERT_SVH
`define GREEDY_LIGATURE_SPAN_DETECTOR_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define GLS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define GLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/gls_pkg.sv
// Package: span type and ligature pattern tables of the span detector.
package gls_pkg;

    localparam int CP_BITS  = 21;
    localparam int OUT_COLS = 16;
    localparam int TRI_NUM  = 8;
    localparam int DUO_NUM  = 22;

    typedef logic [CP_BITS-1:0]  cp_t;
    typedef logic [OUT_COLS-1:0] ocol_t;
    typedef logic [7:0]          ascii_t;

    typedef struct packed {
        ocol_t span_start;
        ocol_t span_end;
        cp_t   char_first;
        cp_t   char_second;
        cp_t   char_third;
    } span_t;

    localparam ascii_t TRI_PAT [TRI_NUM][3] = '{
        '{8'h21, 8'h3D, 8'h3D}, '{8'h3D, 8'h3D, 8'h3D}, '{8'h2D, 8'h2D, 8'h3E},
        '{8'h3C, 8'h2D, 8'h2D}, '{8'h2E, 8'h2E, 8'h2E}, '{8'h2F, 8'h2A, 8'h2A},
        '{8'h3C, 8'h2F, 8'h3E}, '{8'h77, 8'h77, 8'h77}
    };

    localparam ascii_t DUO_PAT [DUO_NUM][2] = '{
        '{8'h3D, 8'h3E}, '{8'h2D, 8'h3E}, '{8'h3C, 8'h2D}, '{8'h21, 8'h3D},
        '{8'h3E, 8'h3D}, '{8'h3C, 8'h3D}, '{8'h3D, 8'h3D}, '{8'h3A, 8'h3A},
        '{8'h2E, 8'h2E}, '{8'h26, 8'h26}, '{8'h7C, 8'h7C}, '{8'h7C, 8'h3E},
        '{8'h3C, 8'h7C}, '{8'h3E, 8'h3E}, '{8'h3C, 8'h3C}, '{8'h2B, 8'h2B},
        '{8'h2D, 8'h2D}, '{8'h2F, 8'h2A}, '{8'h2A, 8'h2F}, '{8'h2F, 8'h2F},
        '{8'h7E, 8'h7E}, '{8'h7E, 8'h3E}
    };

    // Match a three-codepoint window against all 3-character patterns.
    function automatic logic is_tri(cp_t a, cp_t b, cp_t c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < TRI_NUM; i++) begin
            if (a == cp_t'(TRI_PAT[i][0]) && b == cp_t'(TRI_PAT[i][1])
                && c == cp_t'(TRI_PAT[i][2])) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Match a two-codepoint window against all 2-character patterns.
    function automatic logic is_duo(cp_t a, cp_t b);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < DUO_NUM; i++) begin
            if (a == cp_t'(DUO_PAT[i][0]) && b == cp_t'(DUO_PAT[i][1])) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

FILE: design/gls_in_if.sv
// Codepoint channel: valid/ready with one codepoint and its row markers.
interface gls_in_if;
    logic           valid;
    logic           ready;
    gls_pkg::cp_t   codepoint;
    gls_pkg::ocol_t row_start;
    logic           row_last;

    modport source (output valid, output codepoint, output row_start, output row_last,
                    input ready);
    modport sink   (input valid, input codepoint, input row_start, input row_last,
                    output ready);
endinterface

FILE: design/gls_out_if.sv
// Span channel: valid/ready with one detected ligature span.
interface gls_out_if;
    logic           valid;
    logic           ready;
    gls_pkg::ocol_t span_start;
    gls_pkg::ocol_t span_end;
    gls_pkg::cp_t   char_first;
    gls_pkg::cp_t   char_second;
    gls_pkg::cp_t   char_third;

    modport source (output valid, output span_start, output span_end, output char_first,
                    output char_second, output char_third, input ready);
    modport sink   (input valid, input span_start, input span_end, input char_first,
                    input char_second, input char_third, output ready);
endinterface

FILE: design/greedy_ligature_span_detector.sv
// Greedy ligature span detector: one codepoint in per cycle while the skid is empty, spans out.
// A decided span is registered in the result register, or in the skid while that register holds a waiting span.
// Throughput: one item per cycle while the skid is empty; pattern match and window update are one pass.
// A two-entry result stage (register plus skid) keeps input open while a span waits.
// Reset: asynchronous, active low; clears window count, row flag, column and result valids.
module greedy_ligature_span_detector #(
    parameter int COLUMN_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    gls_in_if.sink     codes,
    gls_out_if.source  spans
);

    `include "greedy_ligature_span_detector_assert.svh"

    typedef logic [COLUMN_BITS-1:0] col_t;

    // Window state
    gls_pkg::cp_t  pend0_reg, pend0_next;
    gls_pkg::cp_t  pend1_reg, pend1_next;
    logic [1:0]    count_reg, count_next;
    col_t          col_reg, col_next;
    logic          inside_reg, inside_next;

    // Result stage
    gls_pkg::span_t main_reg, skid_reg;
    logic           main_v_reg, skid_v_reg;

    logic           accept;
    logic           pop;
    logic           hit;
    gls_pkg::span_t res;
    col_t           col_eff;
    logic [1:0]     cnt_eff;
    gls_pkg::cp_t   cp;

    // Fit a column to the 16-bit span fields
    function automatic gls_pkg::ocol_t to_out(col_t c);
        logic [31:0] wide;
        wide = 32'(c);
        return wide[gls_pkg::OUT_COLS-1:0];
    endfunction

    assign codes.ready = !skid_v_reg;
    assign accept      = codes.valid && codes.ready;
    assign pop         = main_v_reg && spans.ready;
    assign cp          = codes.codepoint;

    // Pick up the row start column on the first item of a row
    assign col_eff = inside_reg ? col_reg : col_t'(codes.row_start);
    assign cnt_eff = inside_reg ? count_reg : 2'd0;

    // Resolve the window formed by the pending codepoints and the new one
    always_comb
    begin
        pend0_next  = pend0_reg;
        pend1_next  = pend1_reg;
        count_next  = cnt_eff;
        col_next    = col_eff;
        inside_next = 1'b1;
        hit         = 1'b0;
        res.span_start  = to_out(col_eff);
        res.span_end    = to_out(col_eff + col_t'(2'd2));
        res.char_first  = pend0_reg;
        res.char_second = cp;
        res.char_third  = '0;
        case (cnt_eff)
            2'd0:
            begin
                pend0_next = cp;
                count_next = 2'd1;
            end
            2'd1:
            begin
                hit        = codes.row_last && gls_pkg::is_duo(pend0_reg, cp);
                pend1_next = cp;
                count_next = 2'd2;
            end
            default:
            begin
                if (gls_pkg::is_tri(pend0_reg, pend1_reg, cp)) begin
                    hit             = 1'b1;
                    res.span_end    = to_out(col_eff + col_t'(2'd3));
                    res.char_second = pend1_reg;
                    res.char_third  = cp;
                    col_next        = col_eff + col_t'(2'd3);
                    count_next      = 2'd0;
                end
                else if (gls_pkg::is_duo(pend0_reg, pend1_reg)) begin
                    hit             = 1'b1;
                    res.char_second = pend1_reg;
                    col_next        = col_eff + col_t'(2'd2);
                    pend0_next      = cp;
                    count_next      = 2'd1;
                end
                else begin
                    // Skip one; at row end try the remaining pair
                    hit             = codes.row_last && gls_pkg::is_duo(pend1_reg, cp);
                    res.span_start  = to_out(col_eff + col_t'(2'd1));
                    res.span_end    = to_out(col_eff + col_t'(2'd3));
                    res.char_first  = pend1_reg;
                    col_next        = col_eff + col_t'(2'd1);
                    pend0_next      = pend1_reg;
                    pend1_next      = cp;
                    count_next      = 2'd2;
                end
            end
        endcase
        if (codes.row_last) begin
            count_next  = 2'd0;
            inside_next = 1'b0;
        end
    end

    // Advance control state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg  <= 2'd0;
            inside_reg <= 1'b0;
            col_reg    <= '0;
        end
        else if (accept) begin
            count_reg  <= count_next;
            inside_reg <= inside_next;
            col_reg    <= col_next;
        end
    end

    // Hold pending codepoints
    always_ff @(posedge clk)
    begin
        if (accept) begin
            pend0_reg <= pend0_next;
            pend1_reg <= pend1_next;
        end
    end

    // Result register and skid valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg) begin
            if (pop) begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (accept && hit) begin
            if (main_v_reg && !pop) begin
                skid_v_reg <= 1'b1;
            end
            else begin
                main_v_reg <= 1'b1;
            end
        end
        else if (pop) begin
            main_v_reg <= 1'b0;
        end
    end

    // Result payloads
    always_ff @(posedge clk)
    begin
        if (skid_v_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end
        else if (accept && hit) begin
            if (main_v_reg && !pop) begin
                skid_reg <= res;
            end
            else begin
                main_reg <= res;
            end
        end
    end

    assign spans.valid       = main_v_reg;
    assign spans.span_start  = main_reg.span_start;
    assign spans.span_end    = main_reg.span_end;
    assign spans.char_first  = main_reg.char_first;
    assign spans.char_second = main_reg.char_second;
    assign spans.char_third  = main_reg.char_third;

    // Checks
    `GLS_ASSERT_NOW(a_skid_behind_main, clk, rst_n, skid_v_reg, main_v_reg,
        "skid holds a span while result register is empty")
    `GLS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg != 2'd3,
        "pending count out of range")
    `GLS_ASSERT_NEXT(a_row_end_clears, clk, rst_n, accept && codes.row_last,
        count_reg == 2'd0 && !inside_reg, "row end did not clear the window")
    `GLS_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_v_reg && spans.ready,
        !skid_v_reg && main_v_reg, "skid did not move into the result register")

endmodule

FILE: tb/tb_top.sv
// Testbench for the greedy ligature span detector: random rows, span prediction, checking.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef gls_pkg::cp_t row_t[$];

    typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_TIGHT} rx_mode_t;

    localparam gls_pkg::cp_t CH_BANG  = 21'h21;
    localparam gls_pkg::cp_t CH_DASH  = 21'h2D;
    localparam gls_pkg::cp_t CH_DOT   = 21'h2E;
    localparam gls_pkg::cp_t CH_LT    = 21'h3C;
    localparam gls_pkg::cp_t CH_EQ    = 21'h3D;
    localparam gls_pkg::cp_t CH_GT    = 21'h3E;
    localparam gls_pkg::cp_t CH_W     = 21'h77;
    localparam gls_pkg::cp_t CH_A     = 21'h61;
    localparam gls_pkg::cp_t CP_MAX   = 21'h10FFFF;
    localparam gls_pkg::cp_t CP_ALLON = 21'h1FFFFF;

    // Characters that appear in the ligature patterns, plus a few that never do
    localparam int ALPHA_NUM = 18;
    localparam gls_pkg::cp_t ALPHA [ALPHA_NUM] = '{
        21'h21, 21'h3D, 21'h2D, 21'h3C, 21'h3E, 21'h2E, 21'h2F, 21'h2A, 21'h77,
        21'h3A, 21'h26, 21'h7C, 21'h2B, 21'h7E, 21'h61, 21'h20, 21'h10003D, 21'h0
    };

    localparam int RANDOM_ITEMS = 1350;

    logic clk = 1'b0;
    logic rst_n;

    gls_in_if  codes ();
    gls_out_if spans ();

    greedy_ligature_span_detector dut (
        .clk   (clk),
        .rst_n (rst_n),
        .codes (codes),
        .spans (spans)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predicted spans, oldest first
    gls_pkg::span_t span_q[$];

    // Predictor state: undecided window, current column, row flag
    gls_pkg::cp_t   held_cp [2];
    int             held_n = 0;
    gls_pkg::ocol_t col_pos = '0;
    logic           in_row = 1'b0;

    int errors      = 0;
    int items_sent  = 0;
    int burst_left  = 0;

    // Receiver stall pattern state
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;

    function automatic logic tri_hit(gls_pkg::cp_t a, gls_pkg::cp_t b, gls_pkg::cp_t c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < gls_pkg::TRI_NUM; i++)
        begin
            if (a == gls_pkg::cp_t'(gls_pkg::TRI_PAT[i][0])
                && b == gls_pkg::cp_t'(gls_pkg::TRI_PAT[i][1])
                && c == gls_pkg::cp_t'(gls_pkg::TRI_PAT[i][2]))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic pair_hit(gls_pkg::cp_t a, gls_pkg::cp_t b);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < gls_pkg::DUO_NUM; i++)
        begin
            if (a == gls_pkg::cp_t'(gls_pkg::DUO_PAT[i][0])
                && b == gls_pkg::cp_t'(gls_pkg::DUO_PAT[i][1]))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic gls_pkg::span_t make_span(gls_pkg::ocol_t at, gls_pkg::cp_t a,
                                                 gls_pkg::cp_t b, gls_pkg::cp_t c, int len);
        gls_pkg::span_t sp;
        sp.span_start  = at;
        sp.span_end    = at + gls_pkg::ocol_t'(len);
        sp.char_first  = a;
        sp.char_second = b;
        sp.char_third  = (len == 3) ? c : '0;
        return sp;
    endfunction

    // Append one predicted span to the queue
    function automatic void queue_span(gls_pkg::span_t sp);
        span_q = {span_q, sp};
    endfunction

    // Advance the window by one codepoint; queue the span it decides, if any
    function automatic void predict_span(gls_pkg::cp_t cp, gls_pkg::ocol_t rs, logic last);
        gls_pkg::cp_t win [3];
        int           n;
        win = '{default: '0};
        n = 0;
        if (!in_row)
        begin
            col_pos = rs;
            held_n  = 0;
            in_row  = 1'b1;
        end
        for (int i = 0; i < held_n; i++)
        begin
            win[n] = held_cp[i];
            n++;
        end
        win[n] = cp;
        n++;
        if (n == 3)
        begin
            if (tri_hit(win[0], win[1], win[2]))
            begin
                queue_span(make_span(col_pos, win[0], win[1], win[2], 3));
                col_pos = col_pos + 3;
                held_n  = 0;
            end
            else if (pair_hit(win[0], win[1]))
            begin
                queue_span(make_span(col_pos, win[0], win[1], '0, 2));
                col_pos    = col_pos + 2;
                held_cp[0] = win[2];
                held_n     = 1;
            end
            else
            begin
                // Skip one character; at row end the remaining pair still gets a try
                col_pos    = col_pos + 1;
                held_cp[0] = win[1];
                held_cp[1] = win[2];
                held_n     = 2;
                if (last && pair_hit(win[1], win[2]))
                begin
                    queue_span(make_span(col_pos, win[1], win[2], '0, 2));
                end
            end
        end
        else
        begin
            // Hold a non-final pair: a triple may still complete
            if (n == 2 && last && pair_hit(win[0], win[1]))
            begin
                queue_span(make_span(col_pos, win[0], win[1], '0, 2));
            end
            for (int i = 0; i < n; i++)
            begin
                held_cp[i] = win[i];
            end
            held_n = n;
        end
        if (last)
        begin
            held_n = 0;
            in_row = 1'b0;
        end
    endfunction

    // Predict on every accepted item
    always @(posedge clk)
    begin
        if (rst_n && codes.valid && codes.ready)
        begin
            predict_span(codes.codepoint, codes.row_start, codes.row_last);
        end
    end

    // Check every accepted span against the oldest prediction
    always @(posedge clk)
    begin
        gls_pkg::span_t got;
        gls_pkg::span_t want;
        if (rst_n && spans.valid && spans.ready)
        begin
            got.span_start  = spans.span_start;
            got.span_end    = spans.span_end;
            got.char_first  = spans.char_first;
            got.char_second = spans.char_second;
            got.char_third  = spans.char_third;
            if (span_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected span: start %h end %h chars %h %h %h",
                             got.span_start, got.span_end, got.char_first,
                             got.char_second, got.char_third);
                end
            end
            else
            begin
                want = span_q.pop_front();
                if (got.span_start != want.span_start || got.span_end != want.span_end
                    || got.char_first != want.char_first
                    || got.char_second != want.char_second
                    || got.char_third != want.char_third)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("span mismatch: expected start %h end %h chars %h %h %h",
                                 want.span_start, want.span_end, want.char_first,
                                 want.char_second, want.char_third);
                        $display("               actual   start %h end %h chars %h %h %h",
                                 got.span_start, got.span_end, got.char_first,
                                 got.char_second, got.char_third);
                    end
                end
            end
        end
    end

    // Receiver: switch between open, coin-flip, periodic and tight stall patterns
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(32, 400);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_OPEN:  spans.ready <= 1'b1;
            RX_COIN:  spans.ready <= 1'($urandom_range(0, 1));
            RX_COMB:  spans.ready <= (rx_tick % 7) < 3;
            default:  spans.ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Send one item, in bursts with random gaps between them
    task automatic send_code(gls_pkg::cp_t cp, gls_pkg::ocol_t rs, logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                codes.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        codes.valid     <= 1'b1;
        codes.codepoint <= cp;
        codes.row_start <= rs;
        codes.row_last  <= last;
        do
            @(posedge clk);
        while (!codes.ready);
        items_sent++;
    endtask

    // Send a row; row_start on later items is noise the block must ignore
    task automatic send_row(row_t row, gls_pkg::ocol_t rs);
        for (int i = 0; i < row.size(); i++)
        begin
            send_code(row[i], (i == 0) ? rs : gls_pkg::ocol_t'($urandom_range(0, 65535)),
                      i == row.size() - 1);
        end
    endtask

    // Hold the sender until every predicted span has arrived
    task automatic drain_spans();
        codes.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (span_q.size() != 0);
    endtask

    task automatic test_triples_and_wrap();
        // Triple at the top column, wrapping past zero
        send_row('{CH_BANG, CH_EQ, CH_EQ}, 16'hFFFE);
        // Triple at the last column, then a lone leftover at row end
        send_row('{CH_LT, CH_DASH, CH_DASH, CH_GT}, 16'hFFFF);
        send_row('{CH_W, CH_W, CH_W}, 16'h0000);
    endtask

    task automatic test_row_edges();
        // One-character row gives nothing
        send_row('{CH_EQ}, 16'h0000);
        // Two-character row resolved at row end
        send_row('{CH_DASH, CH_GT}, 16'h1234);
        // Pair decided once the third character rules out a triple
        send_row('{CH_EQ, CH_GT, CH_A}, 16'h00F0);
        // Skip the first of three, then the final pair matches
        send_row('{CH_A, CH_DASH, CH_GT}, 16'hFFFF);
        // Codepoints past the Unicode range never match
        send_row('{CP_ALLON, 21'h10003D, 21'h10003E}, 16'h8000);
        send_row('{CP_MAX, CH_DOT, CH_DOT}, 16'h7FFF);
    endtask

    // Random rows: mostly pattern pieces, some alphabet noise and raw codepoints
    task automatic test_random_rows();
        row_t           row;
        int             target;
        int             pick;
        int             idx;
        int             rows_done;
        int             start_items;
        gls_pkg::ocol_t rs;
        rows_done   = 0;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            row.delete();
            target = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                 : $urandom_range(1, 16);
            while (row.size() < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                begin
                    idx = $urandom_range(0, gls_pkg::TRI_NUM - 1);
                    for (int k = 0; k < 3; k++)
                    begin
                        row = {row, gls_pkg::cp_t'(gls_pkg::TRI_PAT[idx][k])};
                    end
                end
                else if (pick < 60)
                begin
                    idx = $urandom_range(0, gls_pkg::DUO_NUM - 1);
                    for (int k = 0; k < 2; k++)
                    begin
                        row = {row, gls_pkg::cp_t'(gls_pkg::DUO_PAT[idx][k])};
                    end
                end
                else if (pick < 88)
                begin
                    row = {row, ALPHA[$urandom_range(0, ALPHA_NUM - 1)]};
                end
                else
                begin
                    row = {row, gls_pkg::cp_t'($urandom_range(0, 21'h1FFFFF))};
                end
            end
            rs = ($urandom_range(0, 4) == 0)
                 ? gls_pkg::ocol_t'($urandom_range(16'hFFC0, 16'hFFFF))
                 : gls_pkg::ocol_t'($urandom_range(0, 65535));
            send_row(row, rs);
            rows_done++;
            if (rows_done % 97 == 0)
            begin
                drain_spans();
            end
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        codes.valid     = 1'b0;
        codes.codepoint = '0;
        codes.row_start = '0;
        codes.row_last  = 1'b0;
        spans.ready     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_triples_and_wrap();
        drain_spans();
        test_row_edges();
        drain_spans();
        test_random_rows();

        // Let the last spans come out, then allow for the result stage
        drain_spans();
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/gls_pkg.sv
design/gls_in_if.sv
design/gls_out_if.sv
design/greedy_ligature_span_detector.sv
tb/tb_top.sv
